// ===== rtl/dual_pulse_width_id_classifier_assert.svh =====
// assertion macros for the pulse width id classifier
// expects clk and rst in the scope of the including module
`ifndef DUAL_PULSE_WIDTH_ID_CLASSIFIER_ASSERT_SVH
`define DUAL_PULSE_WIDTH_ID_CLASSIFIER_ASSERT_SVH
`ifndef SYNTHESIS
// checked outside reset
`define DPWID_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// checked on every edge, reset included
`define DPWID_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define DPWID_ASSERT(label, prop, msg)
`define DPWID_ASSERT_ALWAYS(label, prop, msg)
`endif
`endif

// ===== rtl/dpwid_pkg.sv =====
// shared types and constants of the pulse width id classifier
// no dependencies
`timescale 1ns / 1ps

package dpwid_pkg;

  localparam int TIMEOUT_W     = 20;
  localparam int ID_W          = 6;
  localparam int BIN_W         = 17;
  localparam int NUM_BINS      = 36;
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 20'd100000;
  localparam logic [BIN_W-1:0]     MIN_WIDTH     = 17'd5;

  typedef logic [BIN_W-1:0] bin_t;

  // upper bound (exclusive) of each id bin, id = index + 1
  localparam bin_t BIN_TOP [NUM_BINS] = '{
    17'd110,   17'd135,   17'd165,   17'd200,   17'd245,   17'd300,
    17'd360,   17'd430,   17'd515,   17'd620,   17'd750,   17'd910,
    17'd1100,  17'd1350,  17'd1650,  17'd2000,  17'd2450,  17'd3000,
    17'd3600,  17'd4300,  17'd5150,  17'd6200,  17'd7500,  17'd9100,
    17'd11000, 17'd13500, 17'd16500, 17'd20000, 17'd24500, 17'd30000,
    17'd36000, 17'd43000, 17'd51500, 17'd62000, 17'd75000, 17'd91000
  };

  // channel status codes
  typedef enum logic [1:0] {
    ST_VALID   = 2'd0,
    ST_INVALID = 2'd1,
    ST_TIMEOUT = 2'd2,
    ST_NOANS   = 2'd3
  } status_t;

  // channel phase, one-hot
  typedef enum logic [2:0] {
    PH_RISE = 3'b001,
    PH_FALL = 3'b010,
    PH_DONE = 3'b100
  } phase_t;

  // per-tick control from the scan sequencer to each channel
  typedef struct packed {
    logic step;   // an item is processed this cycle
    logic start;  // the item starts a scan
    logic scan;   // a scan is running and the item is a plain tick
  } chan_ctl_t;

endpackage

// ===== rtl/dpwid_classify.sv =====
// pulse width to board id lookup over the fixed bin table
// depends on dpwid_pkg
`timescale 1ns / 1ps

module dpwid_classify import dpwid_pkg::*; #(
  parameter int CNT_W = 20
) (
  input  logic [CNT_W-1:0] rise,
  input  logic [CNT_W-1:0] fall,
  output logic [ID_W-1:0]  id
);

  logic [CNT_W:0]      diff;
  logic [CNT_W-1:0]    width;
  logic [NUM_BINS-1:0] below;

  // width with borrow, borrow means falling before rising
  assign diff  = {1'b0, fall} - {1'b0, rise};
  assign width = diff[CNT_W-1:0];

  // independent compare against each bin top
  always_comb begin
    for (int i = 0; i < NUM_BINS; i++) begin
      below[i] = width < CNT_W'(BIN_TOP[i]);
    end
  end

  // first bin that holds the width; zero if none does, on a borrow or below MIN_WIDTH
  always_comb begin
    id = '0;
    for (int i = NUM_BINS - 1; i >= 0; i--) begin
      if (below[i]) begin
        id = ID_W'(i + 1);
      end
    end
    if (diff[CNT_W] || width < CNT_W'(MIN_WIDTH)) begin
      id = '0;
    end
  end

endmodule

// ===== rtl/dpwid_chan.sv =====
// one id channel: edge detect, time stamps, phase and held result
// depends on dpwid_pkg and dpwid_classify
`timescale 1ns / 1ps

module dpwid_chan import dpwid_pkg::*; #(
  parameter int CNT_W = 20
) (
  input  logic             clk,
  input  logic             rst,
  input  chan_ctl_t        ctl,
  input  logic             finish,
  input  logic [CNT_W-1:0] cnt,
  input  logic             lvl,
  output phase_t           phase_next,
  output status_t          status,
  output logic [ID_W-1:0]  id
);

  phase_t           phase;
  logic [CNT_W-1:0] rise_stamp, rise_stamp_next;
  logic [CNT_W-1:0] fall_stamp, fall_stamp_next;
  logic             prev_lvl;
  logic             rise_edge, fall_edge;
  logic [ID_W-1:0]  width_id;
  status_t          status_next;

  assign rise_edge = lvl & ~prev_lvl;
  assign fall_edge = ~lvl & prev_lvl;

  // phase and stamps for the current tick
  always_comb begin
    phase_next      = phase;
    rise_stamp_next = rise_stamp;
    fall_stamp_next = fall_stamp;
    if (ctl.step && ctl.start) begin
      phase_next = PH_RISE;
    end else if (ctl.step && ctl.scan) begin
      if (rise_edge) begin
        phase_next      = PH_FALL;
        rise_stamp_next = cnt;
      end else if (fall_edge) begin
        phase_next      = PH_DONE;
        fall_stamp_next = cnt;
      end
    end
  end

  dpwid_classify #(.CNT_W(CNT_W)) u_classify (
    .rise (rise_stamp_next),
    .fall (fall_stamp_next),
    .id   (width_id)
  );

  // status latched at the end of a scan
  always_comb begin
    unique case (phase_next)
      PH_DONE: status_next = (width_id != '0) ? ST_VALID : ST_INVALID;
      PH_FALL: status_next = ST_TIMEOUT;
      default: status_next = ST_NOANS;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_RISE;
      rise_stamp <= '0;
      fall_stamp <= '0;
      prev_lvl   <= 1'b0;
      status     <= ST_NOANS;
      id         <= '0;
    end else if (ctl.step) begin
      phase      <= phase_next;
      rise_stamp <= rise_stamp_next;
      fall_stamp <= fall_stamp_next;
      prev_lvl   <= lvl;
      if (finish) begin
        status <= status_next;
        id     <= (phase_next == PH_DONE) ? width_id : '0;
      end
    end
  end

endmodule

// ===== rtl/dual_pulse_width_id_classifier.sv =====
// Dual pulse-width ID classifier. Takes one timer tick per cycle and gives one
// result per tick, after the tick passes the input register and then the
// result register that holds the clock line, busy flag and the latched
// status and ID of both channels. One item per cycle is sustained as long as
// out_ready stays high; the single pass from the input register through the
// tick counter, the edge stamps and the bin lookup sets the clock period.
// A start tick clears the counter and raises clock_line; the scan ends when
// both channels saw a falling edge, the counter reaches timeout_ticks or it saturates.
// Status and ID always show the last finished scan. cfg_data writes
// timeout_ticks and is taken in any cycle; write it only while idle.
// Depends on dpwid_pkg, dpwid_chan, dpwid_classify and the assertion header.
`timescale 1ns / 1ps
`include "dual_pulse_width_id_classifier_assert.svh"

module dual_pulse_width_id_classifier import dpwid_pkg::*; #(
  parameter int COUNTER_BITS = 20
) (
  input  logic                 clk,
  input  logic                 rst,
  // configuration
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [TIMEOUT_W-1:0] cfg_data,
  // tick items
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 command,
  input  logic                 line_a_level,
  input  logic                 line_b_level,
  // result items
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 clock_line,
  output logic                 scan_finished,
  output logic                 busy_res,
  output logic [1:0]           status_a,
  output logic [ID_W-1:0]      id_a,
  output logic [1:0]           status_b,
  output logic [ID_W-1:0]      id_b
);

  localparam int CMP_W = (COUNTER_BITS > TIMEOUT_W) ? COUNTER_BITS : TIMEOUT_W;
  localparam logic [COUNTER_BITS-1:0] CNT_MAX = '1;

  logic                    ireg_valid;
  logic                    ireg_cmd, ireg_lvl_a, ireg_lvl_b;
  logic                    res_free, step, in_fire;
  logic [TIMEOUT_W-1:0]    timeout_ticks;
  logic                    scanning, scanning_next;
  logic [COUNTER_BITS-1:0] tick_count, tick_count_next, cnt_new;
  logic                    finish;
  chan_ctl_t               ctl;
  phase_t                  phase_a_next, phase_b_next;
  status_t                 stat_a, stat_b;

  // handshakes
  assign res_free  = ~out_valid | out_ready;
  assign step      = ireg_valid & res_free;
  assign in_ready  = ~ireg_valid | res_free;
  assign in_fire   = in_valid & in_ready;
  assign cfg_ready = 1'b1;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks <= TIMEOUT_RESET;
    end else if (cfg_valid) begin
      timeout_ticks <= cfg_data;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      ireg_valid <= 1'b0;
    end else if (in_fire) begin
      ireg_valid <= 1'b1;
    end else if (step) begin
      ireg_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      ireg_cmd   <= command;
      ireg_lvl_a <= line_a_level;
      ireg_lvl_b <= line_b_level;
    end
  end

  // saturating tick count for this tick
  assign cnt_new = (tick_count == CNT_MAX) ? tick_count : tick_count + 1'b1;

  assign ctl.step  = step;
  assign ctl.start = ireg_cmd;
  assign ctl.scan  = ~ireg_cmd & scanning;

  // end of scan
  assign finish = step & ctl.scan &
                  ((phase_a_next == PH_DONE && phase_b_next == PH_DONE) ||
                   CMP_W'(cnt_new) >= CMP_W'(timeout_ticks) ||
                   cnt_new == CNT_MAX);

  // scan sequencer
  always_comb begin
    scanning_next   = scanning;
    tick_count_next = tick_count;
    priority if (ctl.start) begin
      scanning_next   = 1'b1;
      tick_count_next = '0;
    end else if (ctl.scan) begin
      tick_count_next = cnt_new;
      if (finish) begin
        scanning_next = 1'b0;
      end
    end else begin
      // idle tick, counter holds
      tick_count_next = tick_count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scanning   <= 1'b0;
      tick_count <= '0;
    end else if (step) begin
      scanning   <= scanning_next;
      tick_count <= tick_count_next;
    end
  end

  dpwid_chan #(.CNT_W(COUNTER_BITS)) u_chan_a (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl),
    .finish     (finish),
    .cnt        (cnt_new),
    .lvl        (ireg_lvl_a),
    .phase_next (phase_a_next),
    .status     (stat_a),
    .id         (id_a)
  );

  dpwid_chan #(.CNT_W(COUNTER_BITS)) u_chan_b (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl),
    .finish     (finish),
    .cnt        (cnt_new),
    .lvl        (ireg_lvl_b),
    .phase_next (phase_b_next),
    .status     (stat_b),
    .id         (id_b)
  );

  // result register: held state doubles as the result payload
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid     <= 1'b0;
      scan_finished <= 1'b0;
    end else if (step) begin
      out_valid     <= 1'b1;
      scan_finished <= finish;
    end else if (out_ready) begin
      out_valid     <= 1'b0;
    end
  end

  assign clock_line = scanning;
  assign busy_res   = scanning;
  assign status_a   = stat_a;
  assign status_b   = stat_b;

  // checks
  `DPWID_ASSERT(a_finish_idle, out_valid && scan_finished |-> !busy_res, "finished while busy")
  `DPWID_ASSERT(a_id_a, (stat_a == ST_VALID) == (id_a != '0), "channel a status and id disagree")
  `DPWID_ASSERT(a_id_b, (stat_b == ST_VALID) == (id_b != '0), "channel b status and id disagree")
  `DPWID_ASSERT(a_finish_step, finish |=> scan_finished && !scanning, "scan end not shown")
  `DPWID_ASSERT_ALWAYS(a_reset, rst |=> !out_valid && !scanning, "state left by reset")

endmodule
